// ===== hw/rtl/npd_pkg.sv =====
// Package for the named package deframer: parse phases, byte roles,
// result record and reset values. No dependencies.
package npd_pkg;

  // Parse phase, one-hot
  typedef enum logic [4:0] {
    PH_HUNT    = 5'b00001,
    PH_TYPE    = 5'b00010,
    PH_NAME    = 5'b00100,
    PH_SIZE    = 5'b01000,
    PH_CONTENT = 5'b10000
  } phase_t;

  // Role of one byte in the stream
  typedef enum logic [2:0] {
    ROLE_HUNT     = 3'd0,
    ROLE_PREAMBLE = 3'd1,
    ROLE_TYPE     = 3'd2,
    ROLE_NAME     = 3'd3,
    ROLE_NAME_END = 3'd4,
    ROLE_SIZE     = 3'd5,
    ROLE_CONTENT  = 3'd6
  } role_t;

  // Configuration register indexes
  localparam logic [7:0] REG_PREAMBLE   = 8'd0;
  localparam logic [7:0] REG_TYPE_COUNT = 8'd1;

  localparam logic [7:0]  PREAMBLE_RST   = 8'd85;
  localparam logic [7:0]  TYPE_COUNT_RST = 8'd4;
  localparam logic [7:0]  NAME_END       = 8'd0;
  localparam logic [2:0]  SIZE_BYTES     = 3'd4;

  // One result item
  typedef struct packed {
    logic [2:0]  byte_role;
    logic [7:0]  byte_out;
    logic [7:0]  package_kind;
    logic [31:0] content_length;
    logic        frame_end;
    logic        bad_kind;
  } result_t;

  // Configuration handed to the parser
  typedef struct packed {
    logic [7:0] preamble_value;
    logic [7:0] valid_type_count;
  } cfg_t;

endpackage

// ===== hw/rtl/npd_ifs.sv =====
// Valid/ready channel interfaces of the named package deframer:
// byte input, result output and configuration write. No dependencies.
interface npd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface npd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  byte_role;
  logic [7:0]  byte_out;
  logic [7:0]  package_kind;
  logic [31:0] content_length;
  logic        frame_end;
  logic        bad_kind;
  modport source (output valid, output byte_role, output byte_out, output package_kind,
                  output content_length, output frame_end, output bad_kind, input ready);
  modport sink   (input valid, input byte_role, input byte_out, input package_kind,
                  input content_length, input frame_end, input bad_kind, output ready);
endinterface

interface npd_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== hw/rtl/npd_parser.sv =====
// Framing state of the deframer and the per-byte next-state logic.
// Depends on npd_pkg.
module npd_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  logic [7:0]      data_byte,
  input  npd_pkg::cfg_t   cfg,
  output npd_pkg::result_t res
);

  npd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  kind_r, kind_nxt;
  logic [31:0] size_r, size_nxt;
  logic [2:0]  size_left_r, size_left_nxt;
  logic [31:0] content_left_r, content_left_nxt;

  npd_pkg::role_t role;
  logic end_flag;
  logic bad_flag;
  logic [31:0] size_shifted;

  assign size_shifted = {data_byte, size_r[31:8]};

  always_comb begin
    phase_nxt        = phase_r;
    kind_nxt         = kind_r;
    size_nxt         = size_r;
    size_left_nxt    = size_left_r;
    content_left_nxt = content_left_r;
    role             = npd_pkg::ROLE_HUNT;
    end_flag         = 1'b0;
    bad_flag         = 1'b0;
    case (phase_r)
      npd_pkg::PH_TYPE: begin
        role = npd_pkg::ROLE_TYPE;
        if (data_byte < cfg.valid_type_count) begin
          kind_nxt  = data_byte;
          phase_nxt = npd_pkg::PH_NAME;
        end else begin
          bad_flag  = 1'b1;
          phase_nxt = npd_pkg::PH_HUNT;
        end
      end
      npd_pkg::PH_NAME: begin
        if (data_byte == npd_pkg::NAME_END) begin
          role          = npd_pkg::ROLE_NAME_END;
          phase_nxt     = npd_pkg::PH_SIZE;
          size_left_nxt = npd_pkg::SIZE_BYTES;
          size_nxt      = '0;
        end else begin
          role = npd_pkg::ROLE_NAME;
        end
      end
      npd_pkg::PH_SIZE: begin
        role     = npd_pkg::ROLE_SIZE;
        size_nxt = size_shifted;
        if (size_left_r <= 3'd1) begin
          size_left_nxt = '0;
          if (size_shifted == '0) begin
            end_flag  = 1'b1;
            phase_nxt = npd_pkg::PH_HUNT;
          end else begin
            content_left_nxt = size_shifted;
            phase_nxt        = npd_pkg::PH_CONTENT;
          end
        end else begin
          size_left_nxt = size_left_r - 3'd1;
        end
      end
      npd_pkg::PH_CONTENT: begin
        role = npd_pkg::ROLE_CONTENT;
        if (content_left_r <= 32'd1) begin
          content_left_nxt = '0;
          end_flag         = 1'b1;
          phase_nxt        = npd_pkg::PH_HUNT;
        end else begin
          content_left_nxt = content_left_r - 32'd1;
        end
      end
      default: begin
        phase_nxt = npd_pkg::PH_HUNT;
        if (data_byte == cfg.preamble_value) begin
          role      = npd_pkg::ROLE_PREAMBLE;
          phase_nxt = npd_pkg::PH_TYPE;
        end
      end
    endcase
  end

  always_comb begin
    res.byte_role      = role;
    res.byte_out       = data_byte;
    res.package_kind   = kind_nxt;
    res.content_length = size_nxt;
    res.frame_end      = end_flag;
    res.bad_kind       = bad_flag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= npd_pkg::PH_HUNT;
      kind_r         <= '0;
      size_r         <= '0;
      size_left_r    <= '0;
      content_left_r <= '0;
    end else if (step) begin
      phase_r        <= phase_nxt;
      kind_r         <= kind_nxt;
      size_r         <= size_nxt;
      size_left_r    <= size_left_nxt;
      content_left_r <= content_left_nxt;
    end
  end

endmodule

// ===== hw/rtl/named_package_deframer.sv =====
// Top level of the named package deframer: channels, configuration
// registers and result register. Depends on npd_pkg, npd_ifs, npd_parser.

// Byte-stream deframer for packages of the form preamble, type, NUL-terminated
// name, 4-byte little-endian content size, content. Every accepted byte yields
// exactly one result item giving its role, the byte, the current package type,
// the size register and frame-end / bad-type flags. Throughput is one item per
// clock: the framing update is a single pass of logic from the input port into
// the result register, and a new byte is taken whenever the result register is
// empty or its item is being taken in the same cycle. The result item shows on
// out_if in the cycle after its byte is accepted. A bad type byte returns the
// parser to hunting for the preamble; a zero size ends the package on its last
// size byte. Configuration writes (index 0 preamble value, index 1 valid type
// count) are always accepted; other indexes are ignored. Write them only while
// the block is idle.
module named_package_deframer (
  input  logic clk,
  input  logic rst_n,
  npd_in_if.sink    in_if,
  npd_out_if.source out_if,
  npd_cfg_if.sink   cfg_if
);

  // Configuration registers
  npd_pkg::cfg_t cfg_r;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.preamble_value   <= npd_pkg::PREAMBLE_RST;
      cfg_r.valid_type_count <= npd_pkg::TYPE_COUNT_RST;
    end else if (cfg_if.valid) begin
      if (cfg_if.index == npd_pkg::REG_PREAMBLE) begin
        cfg_r.preamble_value <= cfg_if.wdata;
      end
      if (cfg_if.index == npd_pkg::REG_TYPE_COUNT) begin
        cfg_r.valid_type_count <= cfg_if.wdata;
      end
    end
  end

  // Input handshake: take a byte whenever the result register frees up
  logic out_valid_r;
  logic in_take;

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign in_take     = in_if.valid && in_if.ready;

  npd_pkg::result_t res;

  npd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_take),
    .data_byte (in_if.data_byte),
    .cfg       (cfg_r),
    .res       (res)
  );

  // Result register; payload loads only with a new item
  npd_pkg::result_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      res_r <= res;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.byte_role      = res_r.byte_role;
  assign out_if.byte_out       = res_r.byte_out;
  assign out_if.package_kind   = res_r.package_kind;
  assign out_if.content_length = res_r.content_length;
  assign out_if.frame_end      = res_r.frame_end;
  assign out_if.bad_kind       = res_r.bad_kind;

endmodule

// ===== tb/tb_named_package_deframer.sv =====
// Self-checking bench for named_package_deframer: streams framed packages,
// noise and bad types through the byte channel and checks every result item.
// Depends on npd_pkg, npd_ifs and the RTL of the block.
module tb_named_package_deframer;

  // Index that maps to no register; writes to it must be dropped
  localparam logic [7:0] NO_SUCH_REG = 8'hFF;
  localparam int HOLD_CYCLES = 80;
  localparam int HOLD_EVERY  = 300;

  logic clk;
  logic rst_n;

  npd_in_if  in_ch();
  npd_out_if out_ch();
  npd_cfg_if cfg_ch();

  named_package_deframer uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch),
    .cfg_if(cfg_ch)
  );

  // Stimulus bytes waiting for the driver, and results the deframer owes us
  logic [7:0]        pending_bytes[$];
  npd_pkg::result_t  predicted_results[$];

  int          n_fail      = 0;
  int unsigned bytes_taken = 0;
  int unsigned hold_left   = 0;
  int unsigned holds_done  = 0;
  bit          calm        = 1'b0;  // no random idling on either side while set; hold-offs still run

  // Shadow of the framing registers and of the parser state
  logic [7:0]       framing_preamble   = npd_pkg::PREAMBLE_RST;
  logic [7:0]       framing_type_count = npd_pkg::TYPE_COUNT_RST;
  npd_pkg::phase_t  sh_phase        = npd_pkg::PH_HUNT;
  logic [7:0]       sh_kind         = '0;
  logic [31:0]      sh_size         = '0;
  logic [2:0]       sh_size_left    = '0;
  logic [31:0]      sh_content_left = '0;

  initial begin
    clk = 1'b0;
  end

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Advance the shadow parser by one byte and record the result it implies
  task automatic deframe_byte(input logic [7:0] b);
    npd_pkg::result_t r;
    r           = '0;
    r.byte_out  = b;
    r.byte_role = npd_pkg::ROLE_HUNT;
    case (sh_phase)
      npd_pkg::PH_TYPE: begin
        r.byte_role = npd_pkg::ROLE_TYPE;
        if (b < framing_type_count) begin
          sh_kind  = b;
          sh_phase = npd_pkg::PH_NAME;
        end else begin
          // bad type: kind is kept, back to hunting
          r.bad_kind = 1'b1;
          sh_phase   = npd_pkg::PH_HUNT;
        end
      end
      npd_pkg::PH_NAME: begin
        if (b == npd_pkg::NAME_END) begin
          r.byte_role  = npd_pkg::ROLE_NAME_END;
          sh_phase     = npd_pkg::PH_SIZE;
          sh_size_left = npd_pkg::SIZE_BYTES;
          sh_size      = '0;
        end else begin
          r.byte_role = npd_pkg::ROLE_NAME;
        end
      end
      npd_pkg::PH_SIZE: begin
        r.byte_role = npd_pkg::ROLE_SIZE;
        // little-endian: each new byte enters at the top
        sh_size = {b, sh_size[31:8]};
        if (sh_size_left <= 3'd1) begin
          sh_size_left = '0;
          if (sh_size == '0) begin
            r.frame_end = 1'b1;  // empty content ends the package here
            sh_phase    = npd_pkg::PH_HUNT;
          end else begin
            sh_content_left = sh_size;
            sh_phase        = npd_pkg::PH_CONTENT;
          end
        end else begin
          sh_size_left = sh_size_left - 3'd1;
        end
      end
      npd_pkg::PH_CONTENT: begin
        r.byte_role = npd_pkg::ROLE_CONTENT;
        if (sh_content_left <= 32'd1) begin
          sh_content_left = '0;
          r.frame_end     = 1'b1;
          sh_phase        = npd_pkg::PH_HUNT;
        end else begin
          sh_content_left = sh_content_left - 32'd1;
        end
      end
      default: begin
        sh_phase = npd_pkg::PH_HUNT;
        if (b == framing_preamble) begin
          r.byte_role = npd_pkg::ROLE_PREAMBLE;
          sh_phase    = npd_pkg::PH_TYPE;
        end
      end
    endcase
    r.package_kind   = sh_kind;
    r.content_length = sh_size;
    predicted_results.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      n_fail++;
    end
  endtask

  // Byte driver: next item goes out once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.data_byte <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_bytes.size() != 0 && (calm || $urandom_range(99) >= 38)) begin
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= pending_bytes.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Every accepted byte feeds the shadow parser
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      deframe_byte(in_ch.data_byte);
      bytes_taken <= bytes_taken + 1;
    end
  end

  // Result sink: random stalls, plus long hold-offs so the input backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (holds_done < 2 && bytes_taken >= HOLD_EVERY * (holds_done + 1)) begin
      hold_left    <= HOLD_CYCLES;
      holds_done   <= holds_done + 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= 38);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    npd_pkg::result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (predicted_results.size() == 0) begin
        $error("result item with none pending: byte_out %0h", out_ch.byte_out);
        n_fail++;
      end else begin
        exp_r = predicted_results.pop_front();
        check_field("byte_role", 32'(exp_r.byte_role), 32'(out_ch.byte_role));
        check_field("byte_out", 32'(exp_r.byte_out), 32'(out_ch.byte_out));
        check_field("package_kind", 32'(exp_r.package_kind), 32'(out_ch.package_kind));
        check_field("content_length", exp_r.content_length, out_ch.content_length);
        check_field("frame_end", 32'(exp_r.frame_end), 32'(out_ch.frame_end));
        check_field("bad_kind", 32'(exp_r.bad_kind), 32'(out_ch.bad_kind));
      end
    end
  end

  // One register write; shadow copy follows at the accepting edge
  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == npd_pkg::REG_PREAMBLE) framing_preamble = val;
    else if (idx == npd_pkg::REG_TYPE_COUNT) framing_type_count = val;
  endtask

  // Wait until the channel is empty and every result is back
  task automatic drain();
    @(negedge clk);
    while (pending_bytes.size() != 0 || in_ch.valid || predicted_results.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_le32(input logic [31:0] v);
    for (int i = 0; i < 4; i++) pending_bytes.push_back(v[8*i +: 8]);
  endtask

  // One well-formed package with random name and content
  task automatic queue_package(input int name_len, input logic [31:0] size);
    pending_bytes.push_back(framing_preamble);
    pending_bytes.push_back(8'($urandom_range(framing_type_count - 1, 0)));
    for (int i = 0; i < name_len; i++) pending_bytes.push_back(8'($urandom_range(255, 1)));
    pending_bytes.push_back(npd_pkg::NAME_END);
    push_le32(size);
    for (int i = 0; i < size; i++) pending_bytes.push_back(8'($urandom));
  endtask

  // Mostly packages; the rest is line noise and rejected types.
  // Every sequence leaves the parser hunting.
  task automatic queue_traffic(input int target);
    int counted;
    int pick;
    int mark;
    int name_len;
    logic [31:0] size;
    logic [7:0] junk;
    counted = 0;
    while (counted < target) begin
      pick = $urandom_range(99);
      mark = pending_bytes.size();
      if (pick < 70 && framing_type_count != 0) begin
        name_len = ($urandom_range(19) == 0) ? $urandom_range(40, 20) : $urandom_range(6);
        pick = $urandom_range(99);
        if (pick < 10) size = '0;
        else if (pick < 95) size = $urandom_range(24, 1);
        else size = $urandom_range(300, 25);
        queue_package(name_len, size);
        counted += pending_bytes.size() - mark;
      end else if (pick < 85) begin
        // rejected type byte right after a preamble
        pending_bytes.push_back(framing_preamble);
        pending_bytes.push_back(8'($urandom_range(255, framing_type_count)));
        counted += 2;
      end else begin
        // stray bytes while hunting; not counted
        repeat ($urandom_range(4, 1)) begin
          do junk = 8'($urandom); while (junk == framing_preamble);
          pending_bytes.push_back(junk);
        end
      end
    end
  endtask

  task automatic run_phase(input logic [7:0] pre, input logic [7:0] cnt, input int n_items);
    write_reg(npd_pkg::REG_PREAMBLE, pre);
    write_reg(npd_pkg::REG_TYPE_COUNT, cnt);
    write_reg(NO_SUCH_REG, 8'($urandom));
    @(negedge clk);
    queue_traffic(n_items);
    drain();
  endtask

  initial begin
    logic [7:0] directed[];
    directed = '{
      8'h00,                          // hunting byte
      8'd85, 8'd3,                    // preamble, highest valid type
      8'h61, 8'hFF, 8'd85, 8'h00,     // name with a preamble value inside, end
      8'h02, 8'h00, 8'h00, 8'h00,     // size 2
      8'd85, 8'hAA,                   // content, preamble value inside
      8'd85, 8'd4,                    // type at the count: rejected
      8'd85, 8'd0, 8'h00,             // type 0, empty name
      8'h00, 8'h00, 8'h00, 8'h00,     // zero size ends the package
      8'd85, 8'd85                    // preamble value as type byte: rejected
    };
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    out_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.wdata    = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed pass on the reset framing values
    @(negedge clk);
    foreach (directed[i]) pending_bytes.push_back(directed[i]);
    drain();

    // random phases; one runs with no random idling
    calm <= 1'b1;
    run_phase(8'hA5, 8'd4, 350);
    calm <= 1'b0;
    run_phase(8'h00, 8'd1, 350);
    run_phase(8'hFF, 8'hFF, 350);
    run_phase(8'h7E, 8'd0, 60);      // every type byte rejected
    run_phase(8'h55, 8'd16, 400);
    run_phase(8'h3C, 8'd200, 390);

    if (n_fail == 0 && predicted_results.size() == 0) begin
      $display("tb_named_package_deframer OK");
    end else begin
      $display("tb_named_package_deframer NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("tb_named_package_deframer NOT OK");
    $finish;
  end

endmodule
